// ===== rtl/sprite_row_zoom_pixel_engine_macros.svh =====
// assertion macros used by the checker in rtl/srzpe_checker.sv
`ifndef SPRITE_ROW_ZOOM_PIXEL_ENGINE_MACROS_SVH
`define SPRITE_ROW_ZOOM_PIXEL_ENGINE_MACROS_SVH

// checked only outside reset
`define SRZPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define SRZPE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/srzpe_pkg.sv =====
`default_nettype none

package srzpe_pkg;

   localparam int NUM_LANES  = 4;
   localparam int PIX_W      = 4;
   localparam int WORD_W     = NUM_LANES * PIX_W;
   localparam int ACC_W      = 7;
   localparam int ZOOM_W     = 5;
   localparam int XPOS_W     = 11;
   localparam int START_W    = 10;
   localparam int CLIP_W     = 9;
   localparam int BANK_W     = 8;
   localparam int LEVEL_W    = 2;
   localparam int MASK_W     = 4;
   localparam int COLOR_W    = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int LANE_IDX_W = $clog2(NUM_LANES);

   typedef logic [PIX_W-1:0]         pix_type;
   typedef logic [ACC_W-1:0]         acc_type;
   typedef logic [ZOOM_W-1:0]        zoom_type;
   typedef logic signed [XPOS_W-1:0] xpos_type;
   typedef logic [CLIP_W-1:0]        clip_type;
   typedef logic [BANK_W-1:0]        bank_type;
   typedef logic [LEVEL_W-1:0]       level_type;
   typedef logic [LANE_IDX_W-1:0]    lane_idx_type;
   typedef logic [CSR_IDX_W-1:0]     csr_idx_type;

   localparam logic          OP_ROW  = 1'b0;
   localparam logic          OP_WORD = 1'b1;

   localparam csr_idx_type   CSR_CLIP_LEFT  = CSR_IDX_W'(0);
   localparam csr_idx_type   CSR_CLIP_RIGHT = CSR_IDX_W'(1);
   localparam clip_type      CLIP_LEFT_RESET  = CLIP_W'(0);
   localparam clip_type      CLIP_RIGHT_RESET = CLIP_W'(319);

   localparam acc_type       ACC_START    = ACC_W'(32);
   localparam int            ACC_SKIP_BIT = 6;
   localparam acc_type       ACC_SKIP     = ACC_W'(64);
   localparam xpos_type      XPOS_ONE     = XPOS_W'(1);
   localparam pix_type       PIX_CLEAR    = PIX_W'(0);
   localparam pix_type       PIX_END      = PIX_W'(15);
   localparam logic [COLOR_W-1:0] COLOR_BASE = COLOR_W'(12'h800);
   localparam bank_type      SHADOW_BANK  = BANK_W'(8'h3f);
   localparam lane_idx_type  LANE_LAST    = LANE_IDX_W'(NUM_LANES - 1);

   typedef struct packed {
      xpos_type x;
      pix_type  pix;
      logic     we;
   } lane_out_type;

   typedef struct packed {
      bank_type  bank;
      level_type level;
      logic      done;
   } row_info_type;

   function automatic logic x_le(input xpos_type x, input clip_type c);
      return $signed(x) <= $signed({{(XPOS_W-CLIP_W){1'b0}}, c});
   endfunction

   function automatic logic x_ge(input xpos_type x, input clip_type c);
      return $signed(x) >= $signed({{(XPOS_W-CLIP_W){1'b0}}, c});
   endfunction

endpackage

`default_nettype wire

// ===== rtl/srzpe_if.sv =====
`default_nettype none

interface srzpe_req_if;
   logic                valid;
   logic                ready;
   logic                op;
   logic [15:0]         pixel_word;
   logic signed [9:0]   start_x;
   logic                mirror;
   logic [4:0]          hzoom;
   logic [7:0]          palette_bank;
   logic [1:0]          priority_level;

   modport source (output valid, op, pixel_word, start_x, mirror, hzoom, palette_bank,
                   priority_level, input ready);
   modport sink (input valid, op, pixel_word, start_x, mirror, hzoom, palette_bank,
                 priority_level, output ready);
endinterface

interface srzpe_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [10:0]  screen_x;
   logic [12:0]         color_value;
   logic [3:0]          priority_mask;
   logic                write_enable;
   logic                shadow;
   logic                row_done;
   logic                last;

   modport source (output valid, screen_x, color_value, priority_mask, write_enable, shadow,
                   row_done, last, input ready);
   modport sink (input valid, screen_x, color_value, priority_mask, write_enable, shadow,
                 row_done, last, output ready);
endinterface

interface srzpe_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [8:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srzpe_lane.sv =====
`default_nettype none

module srzpe_lane (
   input  srzpe_pkg::pix_type      pix,
   input  srzpe_pkg::acc_type      acc_in,
   input  srzpe_pkg::xpos_type     x_in,
   input  srzpe_pkg::zoom_type     hzoom,
   input  srzpe_pkg::clip_type     clip_left,
   input  srzpe_pkg::clip_type     clip_right,
   output srzpe_pkg::acc_type      acc_out,
   output srzpe_pkg::xpos_type     x_out,
   output srzpe_pkg::lane_out_type result
);
   import srzpe_pkg::*;

   logic    skip;
   logic    opaque;
   acc_type acc_base;

   assign skip     = acc_in[ACC_SKIP_BIT];
   assign acc_base = skip ? (acc_in & ~ACC_SKIP) : acc_in;
   assign acc_out  = acc_base + {{(ACC_W-ZOOM_W){1'b0}}, hzoom};
   assign x_out    = skip ? x_in : x_in + XPOS_ONE;
   assign opaque   = (pix != PIX_CLEAR) && (pix != PIX_END);

   assign result.x   = x_in;
   assign result.pix = pix;
   assign result.we  = !skip && opaque && x_ge(x_in, clip_left) && x_le(x_in, clip_right);

endmodule

`default_nettype wire

// ===== rtl/srzpe_merge.sv =====
`default_nettype none

module srzpe_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  srzpe_pkg::lane_out_type lanes [srzpe_pkg::NUM_LANES],
   input  srzpe_pkg::row_info_type info,
   output logic                    load_ready,
   srzpe_rsp_if.source             rsp_if
);
   import srzpe_pkg::*;

   lane_out_type ent_ff [NUM_LANES];
   lane_out_type ent_in [NUM_LANES];
   row_info_type info_ff;
   row_info_type info_in;
   logic         valid_ff;
   logic         valid_in;
   lane_idx_type idx_ff;
   lane_idx_type idx_in;
   lane_out_type cur;
   logic         pop;
   logic         last_pop;

   assign pop        = valid_ff && rsp_if.ready;
   assign last_pop   = pop && (idx_ff == LANE_LAST);
   assign load_ready = !valid_ff || last_pop;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      info_in  = info_ff;
      ent_in   = ent_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
         info_in  = info;
         ent_in   = lanes;
      end else if (pop) begin
         idx_in = idx_ff + LANE_IDX_W'(1);
         if (last_pop) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      info_ff <= info_in;
      ent_ff  <= ent_in;
   end

   // result fields of the word at the head of the burst
   assign cur                  = ent_ff[idx_ff];
   assign rsp_if.valid         = valid_ff;
   assign rsp_if.screen_x      = cur.x;
   assign rsp_if.color_value   = COLOR_BASE + {1'b0, info_ff.bank, cur.pix};
   assign rsp_if.priority_mask = MASK_W'(1) << info_ff.level;
   assign rsp_if.write_enable  = cur.we;
   assign rsp_if.shadow        = (info_ff.bank == SHADOW_BANK);
   assign rsp_if.row_done      = info_ff.done;
   assign rsp_if.last          = (idx_ff == LANE_LAST);

endmodule

`default_nettype wire

// ===== rtl/sprite_row_zoom_pixel_engine.sv =====
// Horizontal row engine of a sprite generator.
// req_if: valid/ready channel. op = 0 opens a row (start_x, mirror, hzoom,
//   palette_bank, priority_level); op = 1 carries a word of four 4-bit pixels.
// rsp_if: valid/ready channel, four words per drawn pixel word, last on the
//   fourth. Row starts, words with no open row and words that arrive past the
//   right clip edge give no result.
// csr_if: clip_left (index 0) and clip_right (index 1), always ready; write
//   only while the block is idle.
// Four lanes handle the four pixels of a word in the cycle it is accepted;
// the results are registered and the first one shows on rsp_if the next
// cycle, one result per cycle after that while rsp_if.ready is high; a new
// item is accepted in the cycle the fourth result of the previous word is
// taken, so words stream with no gap.
// Reset (synchronous) clears the row state, clip registers and the result
// buffer. When rsp_if.ready stays low the current result holds and req_if
// is not ready until the fourth result of the burst is taken.

`default_nettype none

module sprite_row_zoom_pixel_engine (
   input  logic         clock,
   input  logic         reset,
   srzpe_req_if.sink    req_if,
   srzpe_rsp_if.source  rsp_if,
   srzpe_csr_if.sink    csr_if
);
   import srzpe_pkg::*;

   clip_type     clip_left_ff, clip_left_in;
   clip_type     clip_right_ff, clip_right_in;
   xpos_type     cur_x_ff, cur_x_in;
   acc_type      zoom_acc_ff, zoom_acc_in;
   logic         row_mirror_ff, row_mirror_in;
   zoom_type     row_hzoom_ff, row_hzoom_in;
   bank_type     row_bank_ff, row_bank_in;
   level_type    row_level_ff, row_level_in;
   logic         row_active_ff, row_active_in;

   acc_type      acc_chain [NUM_LANES+1];
   xpos_type     x_chain [NUM_LANES+1];
   lane_out_type lane_res [NUM_LANES];
   row_info_type info;
   logic         load_ready;
   logic         accept;
   logic         past_edge;
   logic         done;
   logic         load;

   assign csr_if.ready = 1'b1;

   always_comb begin
      clip_left_in  = clip_left_ff;
      clip_right_in = clip_right_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_CLIP_LEFT:  clip_left_in  = csr_if.data;
            CSR_CLIP_RIGHT: clip_right_in = csr_if.data;
            default: ;
         endcase
      end
   end

   assign acc_chain[0] = zoom_acc_ff;
   assign x_chain[0]   = cur_x_ff;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      pix_type pix;
      assign pix = row_mirror_ff ? req_if.pixel_word[PIX_W*i +: PIX_W]
                                 : req_if.pixel_word[PIX_W*(NUM_LANES-1-i) +: PIX_W];
      srzpe_lane u_lane (
         .pix        (pix),
         .acc_in     (acc_chain[i]),
         .x_in       (x_chain[i]),
         .hzoom      (row_hzoom_ff),
         .clip_left  (clip_left_ff),
         .clip_right (clip_right_ff),
         .acc_out    (acc_chain[i+1]),
         .x_out      (x_chain[i+1]),
         .result     (lane_res[i])
      );
   end

   assign accept    = req_if.valid && req_if.ready;
   assign past_edge = !x_le(cur_x_ff, clip_right_ff);
   assign done      = (lane_res[NUM_LANES-1].pix == PIX_END)
                      || !x_le(x_chain[NUM_LANES], clip_right_ff);
   assign load      = accept && (req_if.op == OP_WORD) && row_active_ff && !past_edge;

   assign info.bank  = row_bank_ff;
   assign info.level = row_level_ff;
   assign info.done  = done;

   always_comb begin
      cur_x_in      = cur_x_ff;
      zoom_acc_in   = zoom_acc_ff;
      row_mirror_in = row_mirror_ff;
      row_hzoom_in  = row_hzoom_ff;
      row_bank_in   = row_bank_ff;
      row_level_in  = row_level_ff;
      row_active_in = row_active_ff;
      if (accept) begin
         if (req_if.op == OP_ROW) begin
            cur_x_in      = xpos_type'({req_if.start_x[START_W-1], req_if.start_x});
            row_mirror_in = req_if.mirror;
            row_hzoom_in  = req_if.hzoom;
            row_bank_in   = req_if.palette_bank;
            row_level_in  = req_if.priority_level;
            zoom_acc_in   = ACC_START;
            row_active_in = 1'b1;
         end else if (row_active_ff) begin
            if (past_edge) begin
               row_active_in = 1'b0;
            end else begin
               cur_x_in    = x_chain[NUM_LANES];
               zoom_acc_in = acc_chain[NUM_LANES];
               if (done) begin
                  row_active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff  <= CLIP_LEFT_RESET;
         clip_right_ff <= CLIP_RIGHT_RESET;
         cur_x_ff      <= '0;
         zoom_acc_ff   <= ACC_START;
         row_mirror_ff <= 1'b0;
         row_hzoom_ff  <= '0;
         row_bank_ff   <= '0;
         row_level_ff  <= '0;
         row_active_ff <= 1'b0;
      end else begin
         clip_left_ff  <= clip_left_in;
         clip_right_ff <= clip_right_in;
         cur_x_ff      <= cur_x_in;
         zoom_acc_ff   <= zoom_acc_in;
         row_mirror_ff <= row_mirror_in;
         row_hzoom_ff  <= row_hzoom_in;
         row_bank_ff   <= row_bank_in;
         row_level_ff  <= row_level_in;
         row_active_ff <= row_active_in;
      end
   end

   srzpe_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .lanes      (lane_res),
      .info       (info),
      .load_ready (load_ready),
      .rsp_if     (rsp_if)
   );

   assign req_if.ready = load_ready;

endmodule

`default_nettype wire

// ===== rtl/srzpe_checker.sv =====
`default_nettype none

`include "sprite_row_zoom_pixel_engine_macros.svh"

module srzpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_screen_x,
   input logic [12:0] rsp_color_value,
   input logic        rsp_write_enable,
   input logic        rsp_last
);

   `SRZPE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_screen_x, rsp_color_value}), "stalled result word changed")
   `SRZPE_ASSERT(a_stall_blocks_req, rsp_valid && !rsp_ready |-> !req_ready, "input taken while result stalled")
   `SRZPE_ASSERT(a_burst_continues, rsp_valid && rsp_ready && !rsp_last |=> rsp_valid, "result burst broken before last")
   `SRZPE_ASSERT(a_we_opaque, rsp_valid && rsp_write_enable |-> (rsp_color_value[3:0] != 4'h0) && (rsp_color_value[3:0] != 4'hf), "write on transparent pixel")
   `SRZPE_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind sprite_row_zoom_pixel_engine srzpe_checker u_srzpe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_screen_x     (rsp_if.screen_x),
   .rsp_color_value  (rsp_if.color_value),
   .rsp_write_enable (rsp_if.write_enable),
   .rsp_last         (rsp_if.last)
);

`default_nettype wire

// ===== tb/sprite_row_zoom_pixel_engine_checker.sv =====
`default_nettype none

module sprite_row_zoom_pixel_engine_checker
   import srzpe_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   srzpe_req_if  req_if,
   srzpe_rsp_if  rsp_if,
   srzpe_csr_if  csr_if,
   output int    error_count,
   output int    pixels_owed
);

   typedef struct packed {
      xpos_type           x;
      logic [COLOR_W-1:0] color;
      logic [MASK_W-1:0]  mask;
      logic               we;
      logic               shadow;
      logic               done;
      logic               last;
   } pixel_out_type;

   pixel_out_type pixel_fifo[$];

   clip_type  clip_left;
   clip_type  clip_right;
   int        cur_x;
   acc_type   zoom_acc;
   logic      row_mirror;
   zoom_type  row_zoom;
   bank_type  row_bank;
   level_type row_level;
   logic      row_open;
   int        fail_n = 0;

   initial begin
      error_count = 0;
      pixels_owed = 0;
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_n++;
      end
   endfunction

   // four lanes of one pixel word, high nibble first unless mirrored
   task automatic render_word(input logic [WORD_W-1:0] pixels);
      pix_type       p[NUM_LANES];
      int            xs[NUM_LANES];
      logic          we[NUM_LANES];
      logic          done;
      int            sh;
      pixel_out_type r;
      if (!row_open) return;
      if (cur_x > int'(clip_right)) begin
         row_open = 1'b0;
         return;
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         sh = row_mirror ? PIX_W * i : PIX_W * (NUM_LANES - 1 - i);
         p[i] = pixels[sh +: PIX_W];
         xs[i] = cur_x;
         we[i] = 1'b0;
         if (zoom_acc < ACC_SKIP) begin
            we[i] = p[i] != PIX_CLEAR && p[i] != PIX_END &&
                    cur_x >= int'(clip_left) && cur_x <= int'(clip_right);
            cur_x++;
         end else begin
            zoom_acc = zoom_acc - ACC_SKIP;
         end
         zoom_acc = zoom_acc + acc_type'(row_zoom);
      end
      done = p[NUM_LANES-1] == PIX_END || cur_x > int'(clip_right);
      if (done) row_open = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         r.x      = xpos_type'(xs[i]);
         r.color  = COLOR_BASE + (COLOR_W'(row_bank) << PIX_W) + COLOR_W'(p[i]);
         r.mask   = MASK_W'(1) << row_level;
         r.we     = we[i];
         r.shadow = row_bank == SHADOW_BANK;
         r.done   = done;
         r.last   = i == NUM_LANES - 1;
         pixel_fifo.push_back(r);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_out_type want;
      if (reset) begin
         clip_left  = CLIP_LEFT_RESET;
         clip_right = CLIP_RIGHT_RESET;
         cur_x      = 0;
         zoom_acc   = ACC_START;
         row_mirror = 1'b0;
         row_zoom   = '0;
         row_bank   = '0;
         row_level  = '0;
         row_open   = 1'b0;
         pixel_fifo.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pixel_fifo.size() == 0) begin
               $error("unexpected pixel word at screen_x %0d", $signed(rsp_if.screen_x));
               fail_n++;
            end else begin
               want = pixel_fifo.pop_front();
               check_field("screen_x", $signed(want.x), $signed(rsp_if.screen_x));
               check_field("color_value", want.color, rsp_if.color_value);
               check_field("priority_mask", want.mask, rsp_if.priority_mask);
               check_field("write_enable", want.we, rsp_if.write_enable);
               check_field("shadow", want.shadow, rsp_if.shadow);
               check_field("row_done", want.done, rsp_if.row_done);
               check_field("last", want.last, rsp_if.last);
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.op == OP_ROW) begin
               cur_x      = $signed(req_if.start_x);
               row_mirror = req_if.mirror;
               row_zoom   = req_if.hzoom;
               row_bank   = req_if.palette_bank;
               row_level  = req_if.priority_level;
               zoom_acc   = ACC_START;
               row_open   = 1'b1;
            end else begin
               render_word(req_if.pixel_word);
            end
         end
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == CSR_CLIP_LEFT) begin
               clip_left = csr_if.data;
            end else begin
               clip_right = csr_if.data;
            end
         end
      end
      error_count <= fail_n;
      pixels_owed <= pixel_fifo.size();
   end

endmodule

`default_nettype wire

// ===== tb/sprite_row_zoom_pixel_engine_test.sv =====
`default_nettype none

module sprite_row_zoom_pixel_engine_test;
   import srzpe_pkg::*;

   localparam int IDLE_PCT     = 27;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 10;

   typedef struct packed {
      logic                      op;
      logic [WORD_W-1:0]         pixels;
      logic signed [START_W-1:0] col;
      logic                      mir;
      zoom_type                  zoom;
      bank_type                  bank;
      level_type                 level;
   } sprite_item_type;

   logic clock;
   logic reset;
   logic steady;
   int   error_count;
   int   pixels_owed;

   srzpe_req_if req_if ();
   srzpe_rsp_if rsp_if ();
   srzpe_csr_if csr_if ();

   sprite_row_zoom_pixel_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   sprite_row_zoom_pixel_engine_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_if      (csr_if),
      .error_count (error_count),
      .pixels_owed (pixels_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic sprite_item_type row_start(input int col, input logic mir,
                                                 input int zoom, input int bank,
                                                 input int level);
      sprite_item_type it;
      it.op     = OP_ROW;
      it.pixels = WORD_W'($urandom);
      it.col    = START_W'(col);
      it.mir    = mir;
      it.zoom   = zoom_type'(zoom);
      it.bank   = bank_type'(bank);
      it.level  = level_type'(level);
      return it;
   endfunction

   function automatic sprite_item_type pixel_word(input logic [WORD_W-1:0] w);
      sprite_item_type it;
      it.op     = OP_WORD;
      it.pixels = w;
      it.col    = START_W'($urandom);
      it.mir    = 1'($urandom);
      it.zoom   = zoom_type'($urandom);
      it.bank   = bank_type'($urandom);
      it.level  = level_type'($urandom);
      return it;
   endfunction

   // end-of-row nibble forced now and then so rows close early
   function automatic logic [WORD_W-1:0] random_pixels();
      logic [WORD_W-1:0] w;
      w = WORD_W'($urandom);
      if ($urandom_range(4) == 0) begin
         if ($urandom_range(1) == 1) begin
            w[PIX_W-1:0] = PIX_END;
         end else begin
            w[WORD_W-1 -: PIX_W] = PIX_END;
         end
      end
      return w;
   endfunction

   task automatic send(input sprite_item_type it);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.op             <= it.op;
      req_if.pixel_word     <= it.pixels;
      req_if.start_x        <= it.col;
      req_if.mirror         <= it.mir;
      req_if.hzoom          <= it.zoom;
      req_if.palette_bank   <= it.bank;
      req_if.priority_level <= it.level;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pixels_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_clip(input clip_type left, input clip_type right);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_CLIP_LEFT;
      csr_if.data  <= left;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.index <= CSR_CLIP_RIGHT;
      csr_if.data  <= right;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   task automatic random_phase(input int right, input int budget);
      int sent;
      int words;
      int col;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(7) == 0) begin
            send(pixel_word(random_pixels()));
            sent++;
         end else begin
            case ($urandom_range(3))
               0: begin
                  col = right - int'($urandom_range(40));
               end
               1: begin
                  col = int'($urandom_range(1023)) - 512;
               end
               default: begin
                  col = int'($urandom_range(511)) - 184;
               end
            endcase
            send(row_start(col, 1'($urandom), $urandom_range(31),
                           ($urandom_range(5) == 0) ? SHADOW_BANK : $urandom_range(255),
                           $urandom_range(3)));
            words = $urandom_range(1, 8);
            repeat (words) send(pixel_word(random_pixels()));
            sent += words + 1;
         end
      end
   endtask

   initial begin : stimulus
      int left_col;
      int right_col;
      reset                 = 1'b1;
      steady                = 1'b0;
      req_if.valid          = 1'b0;
      req_if.op             = OP_ROW;
      req_if.pixel_word     = '0;
      req_if.start_x        = '0;
      req_if.mirror         = 1'b0;
      req_if.hzoom          = '0;
      req_if.palette_bank   = '0;
      req_if.priority_level = '0;
      rsp_if.ready          = 1'b0;
      csr_if.valid          = 1'b0;
      csr_if.index          = CSR_CLIP_LEFT;
      csr_if.data           = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset clip window
      send(pixel_word(16'hffff));
      send(row_start(0, 1'b0, 0, 0, 0));
      send(pixel_word(16'h1234));
      send(pixel_word(16'h0f0e));
      send(row_start(-184, 1'b1, 31, SHADOW_BANK, 3));
      send(pixel_word(16'h8421));
      send(pixel_word(16'hf00f));
      send(pixel_word(16'h5555));
      send(row_start(318, 1'b0, 0, 255, 2));
      send(pixel_word(16'h1234));
      send(row_start(327, 1'b1, 5, 17, 1));
      send(pixel_word(16'h6666));
      send(pixel_word(16'h7777));
      send(row_start(-1, 1'b0, 16, 1, 1));
      send(pixel_word(16'habcd));
      send(pixel_word(16'h6789));
      send(pixel_word(16'h0000));
      send(row_start(100, 1'b1, 8, 128, 0));
      send(pixel_word(16'hffff));
      send(row_start(-512, 1'b0, 1, 0, 3));
      send(pixel_word(16'h0123));
      send(row_start(511, 1'b0, 2, 64, 2));
      send(pixel_word(16'h4321));
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               left_col  = 0;
               right_col = 511;
            end
            1: begin
               left_col  = 511;
               right_col = 0;
            end
            2: begin
               left_col  = 0;
               right_col = 0;
            end
            3: begin
               left_col  = $urandom_range(511);
               right_col = $urandom_range(511);
            end
            4: begin
               left_col  = 40;
               right_col = 280;
            end
            default: begin
               left_col  = 511;
               right_col = 511;
            end
         endcase
         set_clip(clip_type'(left_col), clip_type'(right_col));
         steady <= (ph == 4);
         random_phase(right_col, PHASE_ITEMS);
         settle();
      end

      if (error_count == 0 && pixels_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sprite_row_zoom_pixel_engine.f =====
+incdir+rtl
rtl/srzpe_pkg.sv
rtl/srzpe_if.sv
rtl/srzpe_lane.sv
rtl/srzpe_merge.sv
rtl/sprite_row_zoom_pixel_engine.sv
rtl/srzpe_checker.sv
tb/sprite_row_zoom_pixel_engine_checker.sv
tb/sprite_row_zoom_pixel_engine_test.sv
